// ----- rtl/ilsp_pkg.sv -----
// shared constants, codes, command and status types of the ini line stream parser
package ilsp_pkg;

    localparam int SPACE_RUN_DEPTH = 32;
    localparam int LINE_BITS       = 24;
    localparam int RUN_AW          = $clog2(SPACE_RUN_DEPTH);
    localparam int RUN_CW          = $clog2(SPACE_RUN_DEPTH + 1);

    // input item kinds
    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_EOS    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // result events
    localparam logic [2:0] EV_SECT_CLEAR  = 3'd0;
    localparam logic [2:0] EV_SECT_BYTE   = 3'd1;
    localparam logic [2:0] EV_SECT_COMMIT = 3'd2;
    localparam logic [2:0] EV_NAME_BYTE   = 3'd3;
    localparam logic [2:0] EV_VALUE_BYTE  = 3'd4;
    localparam logic [2:0] EV_PAIR_DONE   = 3'd5;
    localparam logic [2:0] EV_LINE_ERROR  = 3'd6;
    localparam logic [2:0] EV_STREAM_DONE = 3'd7;

    // line phases
    localparam logic [3:0] PH_START     = 4'd0;
    localparam logic [3:0] PH_COMMENT   = 4'd1;
    localparam logic [3:0] PH_SECT      = 4'd2;
    localparam logic [3:0] PH_SECT_DONE = 4'd3;
    localparam logic [3:0] PH_SECT_BAD  = 4'd4;
    localparam logic [3:0] PH_NAME      = 4'd5;
    localparam logic [3:0] PH_NAME_BAD  = 4'd6;
    localparam logic [3:0] PH_VAL_SKIP  = 4'd7;
    localparam logic [3:0] PH_VAL       = 4'd8;
    localparam logic [3:0] PH_VAL_DONE  = 4'd9;

    // byte-order mark progress value meaning window closed
    localparam logic [1:0] BOM_CLOSED = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_IDLE    = 4'd0;
    localparam logic [3:0] OP_LATCH   = 4'd1;
    localparam logic [3:0] OP_START   = 4'd2;
    localparam logic [3:0] OP_FEED    = 4'd3;
    localparam logic [3:0] OP_FLUSH   = 4'd4;
    localparam logic [3:0] OP_PEND    = 4'd5;
    localparam logic [3:0] OP_ENDLINE = 4'd6;
    localparam logic [3:0] OP_DONE    = 4'd7;
    localparam logic [3:0] OP_FINISH  = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic       use_bom;
        logic       bom_idx;
    } ilsp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_nul;
        logic       is_lf;
        logic       bom_open;
        logic       bom_match;
        logic [1:0] bom_prog;
        logic       flush_start;
        logic       flush_last;
        logic       stall;
    } ilsp_status_t;

    // utf-8 byte-order mark bytes
    function automatic logic [7:0] bom_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hEF;
            2'd1:    b = 8'hBB;
            default: b = 8'hBF;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/ilsp_datapath.sv -----
// parser datapath: line state, whitespace run memory, event hold and output registers
module ilsp_datapath
    import ilsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ilsp_cmd_t    cmd,
    output ilsp_status_t status,
    input  logic [1:0]   s_tuser,
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    // latched input item
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [23:0] rej_reg;

    // parser state
    logic [3:0]           phase_reg;
    logic                 prev_reg;
    logic [RUN_CW-1:0]    count_reg;
    logic [LINE_BITS-1:0] lc_reg;
    logic [LINE_BITS-1:0] fe_reg;
    logic [1:0]           prog_reg;
    logic                 lhb_reg;
    logic                 ovf_reg;

    // flush sequencing
    logic [7:0]        run_mem [SPACE_RUN_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [RUN_CW-1:0] fl_n_reg;
    logic [RUN_AW-1:0] fl_idx_reg;
    logic [2:0]        fl_ev_reg;
    logic [2:0]        pend_ev_reg;
    logic [7:0]        pend_b_reg;

    // one-event hold so the final event of an item can be marked
    logic                 hold_v_reg;
    logic [2:0]           hold_ev_reg;
    logic [7:0]           hold_b_reg;
    logic [LINE_BITS-1:0] hold_ln_reg;
    logic [LINE_BITS-1:0] hold_fe_reg;
    logic                 hold_ov_reg;

    // output register
    logic                 m_v_reg;
    logic [2:0]           m_ev_reg;
    logic [7:0]           m_b_reg;
    logic [LINE_BITS-1:0] m_ln_reg;
    logic [LINE_BITS-1:0] m_fe_reg;
    logic                 m_ov_reg;
    logic                 m_last_reg;

    logic [7:0] x;
    logic       is_ws, is_cmt, is_sep;
    logic [3:0] ph_n;
    logic       prev_n, do_hold, do_clr, do_flush;
    logic [2:0] fl_ev_n;
    logic       f_v;
    logic [2:0] f_ev;
    logic [7:0] f_b;
    logic       flush_start;
    logic       el_v;
    logic [2:0] el_ev;
    logic       el_err;
    logic [LINE_BITS-1:0] fe_n;
    logic       em_v;
    logic [2:0] em_ev;
    logic [7:0] em_b;
    logic       out_free, can_emit, stall, push, push_last;
    logic       run_wr, rd_en;
    logic [RUN_AW-1:0] rd_addr;
    logic [LINE_BITS-1:0] rej_line;

    assign x      = cmd.use_bom ? bom_byte({1'b0, cmd.bom_idx}) : byte_reg;
    assign is_ws  = (x == 8'h20) || (x inside {[8'h09:8'h0D]});
    assign is_cmt = (x == 8'h3B) || (x == 8'h23);
    assign is_sep = (x == 8'h3D) || (x == 8'h3A);
    assign rej_line = LINE_BITS'(rej_reg);

    // one step of the per-line classifier
    always_comb begin
        ph_n     = phase_reg;
        prev_n   = prev_reg;
        do_hold  = 1'b0;
        do_clr   = 1'b0;
        do_flush = 1'b0;
        fl_ev_n  = EV_SECT_BYTE;
        f_v      = 1'b0;
        f_ev     = EV_SECT_CLEAR;
        f_b      = 8'd0;
        case (phase_reg)
            PH_START: begin
                if (is_ws) begin
                    ph_n = phase_reg;
                end else if (is_cmt) begin
                    ph_n = PH_COMMENT;
                end else if (x == 8'h5B) begin
                    f_v    = 1'b1;
                    f_ev   = EV_SECT_CLEAR;
                    ph_n   = PH_SECT;
                    prev_n = 1'b0;
                end else if (is_sep) begin
                    ph_n   = PH_VAL_SKIP;
                    prev_n = 1'b0;
                end else begin
                    f_v    = 1'b1;
                    f_ev   = EV_NAME_BYTE;
                    f_b    = x;
                    ph_n   = PH_NAME;
                    prev_n = 1'b0;
                end
            end
            PH_SECT: begin
                if (is_ws) begin
                    do_hold = 1'b1;
                end else if (x == 8'h5D) begin
                    do_flush = 1'b1;
                    fl_ev_n  = EV_SECT_BYTE;
                    f_v      = 1'b1;
                    f_ev     = EV_SECT_COMMIT;
                    ph_n     = PH_SECT_DONE;
                end else if (prev_reg && is_cmt) begin
                    do_clr = 1'b1;
                    ph_n   = PH_SECT_BAD;
                end else begin
                    do_flush = 1'b1;
                    fl_ev_n  = EV_SECT_BYTE;
                    f_v      = 1'b1;
                    f_ev     = EV_SECT_BYTE;
                    f_b      = x;
                    prev_n   = 1'b0;
                end
            end
            PH_NAME: begin
                if (is_ws) begin
                    do_hold = 1'b1;
                end else if (is_sep) begin
                    do_clr = 1'b1;
                    prev_n = 1'b0;
                    ph_n   = PH_VAL_SKIP;
                end else if (prev_reg && is_cmt) begin
                    do_clr = 1'b1;
                    ph_n   = PH_NAME_BAD;
                end else begin
                    do_flush = 1'b1;
                    fl_ev_n  = EV_NAME_BYTE;
                    f_v      = 1'b1;
                    f_ev     = EV_NAME_BYTE;
                    f_b      = x;
                    prev_n   = 1'b0;
                end
            end
            PH_VAL_SKIP: begin
                if (is_ws) begin
                    prev_n = 1'b1;
                end else if (prev_reg && is_cmt) begin
                    ph_n = PH_VAL_DONE;
                end else begin
                    f_v    = 1'b1;
                    f_ev   = EV_VALUE_BYTE;
                    f_b    = x;
                    prev_n = 1'b0;
                    ph_n   = PH_VAL;
                end
            end
            PH_VAL: begin
                if (is_ws) begin
                    do_hold = 1'b1;
                end else if (prev_reg && is_cmt) begin
                    do_clr = 1'b1;
                    ph_n   = PH_VAL_DONE;
                end else begin
                    do_flush = 1'b1;
                    fl_ev_n  = EV_VALUE_BYTE;
                    f_v      = 1'b1;
                    f_ev     = EV_VALUE_BYTE;
                    f_b      = x;
                    prev_n   = 1'b0;
                end
            end
            default: begin
                ph_n = phase_reg;
            end
        endcase
        if (do_hold) begin
            prev_n = 1'b1;
        end
    end

    assign flush_start = do_flush && (count_reg != '0);

    // line end event
    always_comb begin
        el_v   = 1'b0;
        el_ev  = EV_PAIR_DONE;
        el_err = 1'b0;
        case (phase_reg)
            PH_SECT, PH_SECT_BAD, PH_NAME, PH_NAME_BAD: begin
                el_v   = lhb_reg;
                el_ev  = EV_LINE_ERROR;
                el_err = 1'b1;
            end
            PH_VAL_SKIP, PH_VAL, PH_VAL_DONE: begin
                el_v = lhb_reg;
            end
            default: begin
                el_v = 1'b0;
            end
        endcase
        fe_n = (el_err && (fe_reg == '0)) ? lc_reg : fe_reg;
    end

    // event selection and stall
    always_comb begin
        em_v  = 1'b0;
        em_ev = EV_SECT_CLEAR;
        em_b  = 8'd0;
        case (cmd.op)
            OP_FEED: begin
                em_v  = f_v && !flush_start;
                em_ev = f_ev;
                em_b  = f_b;
            end
            OP_FLUSH: begin
                em_v  = 1'b1;
                em_ev = fl_ev_reg;
                em_b  = rd_data_reg;
            end
            OP_PEND: begin
                em_v  = 1'b1;
                em_ev = pend_ev_reg;
                em_b  = pend_b_reg;
            end
            OP_ENDLINE: begin
                em_v  = el_v;
                em_ev = el_ev;
            end
            OP_DONE: begin
                em_v  = 1'b1;
                em_ev = EV_STREAM_DONE;
            end
            default: begin
                em_v = 1'b0;
            end
        endcase
    end

    assign out_free  = !m_v_reg || m_tready;
    assign can_emit  = !hold_v_reg || out_free;
    assign stall     = (em_v && !can_emit) ||
                       ((cmd.op == OP_FINISH) && hold_v_reg && !out_free);
    assign push_last = (cmd.op == OP_FINISH);
    assign push      = hold_v_reg && !stall && (em_v || push_last);

    assign run_wr  = (cmd.op == OP_FEED) && do_hold && !stall &&
                     (count_reg < RUN_CW'(SPACE_RUN_DEPTH));
    assign rd_en   = ((cmd.op == OP_FEED) && flush_start) ||
                     ((cmd.op == OP_FLUSH) && !stall);
    assign rd_addr = (cmd.op == OP_FLUSH) ? fl_idx_reg + 1'b1 : '0;

    // whitespace run memory
    always_ff @(posedge aclk) begin
        if (run_wr) begin
            run_mem[count_reg[RUN_AW-1:0]] <= x;
        end
        if (rd_en) begin
            rd_data_reg <= run_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LATCH) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata[7:0];
            rej_reg  <= s_tdata[31:8];
        end
        if ((cmd.op == OP_FEED) && flush_start) begin
            fl_n_reg    <= count_reg;
            fl_ev_reg   <= fl_ev_n;
            pend_ev_reg <= f_ev;
            pend_b_reg  <= f_b;
        end
        if ((cmd.op == OP_FEED) && flush_start) begin
            fl_idx_reg <= '0;
        end else if ((cmd.op == OP_FLUSH) && !stall) begin
            fl_idx_reg <= fl_idx_reg + 1'b1;
        end
        if (em_v && !stall) begin
            hold_ev_reg <= em_ev;
            hold_b_reg  <= em_b;
            hold_ln_reg <= lc_reg;
            hold_fe_reg <= (cmd.op == OP_ENDLINE) ? fe_n : fe_reg;
            hold_ov_reg <= ovf_reg;
        end
        if (push) begin
            m_ev_reg   <= hold_ev_reg;
            m_b_reg    <= hold_b_reg;
            m_ln_reg   <= hold_ln_reg;
            m_fe_reg   <= hold_fe_reg;
            m_ov_reg   <= hold_ov_reg;
            m_last_reg <= push_last;
        end
    end

    // parser state and handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            prev_reg   <= 1'b0;
            count_reg  <= '0;
            lc_reg     <= '0;
            fe_reg     <= '0;
            prog_reg   <= '0;
            lhb_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            hold_v_reg <= 1'b0;
            m_v_reg    <= 1'b0;
        end else begin
            if (push) begin
                m_v_reg <= 1'b1;
            end else if (m_tready) begin
                m_v_reg <= 1'b0;
            end
            if (em_v && !stall) begin
                hold_v_reg <= 1'b1;
            end else if (push_last && !stall) begin
                hold_v_reg <= 1'b0;
            end
            if (!stall) begin
                case (cmd.op)
                    OP_START: begin
                        if ((kind_reg == KIND_TEXT) && (byte_reg != 8'd0)) begin
                            if (!lhb_reg) begin
                                lhb_reg <= 1'b1;
                                if (lc_reg != '1) begin
                                    lc_reg <= lc_reg + 1'b1;
                                end
                            end
                            if (prog_reg != BOM_CLOSED) begin
                                prog_reg <= (byte_reg == bom_byte(prog_reg)) ?
                                            prog_reg + 1'b1 : BOM_CLOSED;
                            end
                        end else if (kind_reg == KIND_EOS) begin
                            prog_reg <= BOM_CLOSED;
                        end else if (kind_reg == KIND_REJECT) begin
                            if ((rej_line != '0) &&
                                ((fe_reg == '0) || (rej_line < fe_reg))) begin
                                fe_reg <= rej_line;
                            end
                        end
                    end
                    OP_FEED: begin
                        phase_reg <= ph_n;
                        prev_reg  <= prev_n;
                        if (do_hold) begin
                            if (count_reg < RUN_CW'(SPACE_RUN_DEPTH)) begin
                                count_reg <= count_reg + 1'b1;
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end else if (do_clr || do_flush) begin
                            count_reg <= '0;
                        end
                    end
                    OP_ENDLINE: begin
                        if (lhb_reg) begin
                            fe_reg    <= fe_n;
                            phase_reg <= PH_START;
                            prev_reg  <= 1'b0;
                            count_reg <= '0;
                            lhb_reg   <= 1'b0;
                        end
                    end
                    OP_DONE: begin
                        phase_reg <= PH_START;
                        prev_reg  <= 1'b0;
                        count_reg <= '0;
                        lc_reg    <= '0;
                        fe_reg    <= '0;
                        prog_reg  <= '0;
                        lhb_reg   <= 1'b0;
                        ovf_reg   <= 1'b0;
                    end
                    default: begin
                        lhb_reg <= lhb_reg;
                    end
                endcase
            end
        end
    end

    // status toward the controller
    always_comb begin
        status.kind        = kind_reg;
        status.is_nul      = (byte_reg == 8'd0);
        status.is_lf       = (byte_reg == 8'h0A);
        status.bom_open    = (prog_reg != BOM_CLOSED);
        status.bom_match   = (byte_reg == bom_byte(prog_reg));
        status.bom_prog    = prog_reg;
        status.flush_start = (cmd.op == OP_FEED) && flush_start;
        status.flush_last  = ({1'b0, fl_idx_reg} + 1'b1) == fl_n_reg;
        status.stall       = stall;
    end

    assign m_tvalid = m_v_reg;
    assign m_tuser  = m_ev_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_ov_reg, 24'(m_fe_reg), 24'(m_ln_reg), m_b_reg};

endmodule

// ----- rtl/ilsp_ctrl.sv -----
// parser controller: sequences latch, mark replay, classify, flush and close steps
module ilsp_ctrl
    import ilsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ilsp_status_t status,
    output ilsp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_FEED   = 3'd2;
    localparam logic [2:0] S_FLUSH  = 3'd3;
    localparam logic [2:0] S_PEND   = 3'd4;
    localparam logic [2:0] S_EOS    = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] rep_left_reg, rep_left_next;
    logic       rep_idx_reg, rep_idx_next;
    logic [1:0] rep_after;
    logic [2:0] after_feed;
    logic [1:0] rep_load;

    assign s_tready = (state_reg == S_IDLE);

    // where to go once one classified byte is finished
    always_comb begin
        rep_after = (rep_left_reg != 2'd0) ? rep_left_reg - 2'd1 : 2'd0;
        if (rep_left_reg == 2'd0) begin
            after_feed = S_FINISH;
        end else if (rep_after != 2'd0) begin
            after_feed = S_FEED;
        end else if (status.kind == KIND_EOS) begin
            after_feed = S_EOS;
        end else begin
            after_feed = S_FEED;
        end
        rep_load = status.bom_open ? status.bom_prog : 2'd0;
    end

    // command decode
    always_comb begin
        cmd.use_bom = (rep_left_reg != 2'd0);
        cmd.bom_idx = rep_idx_reg;
        case (state_reg)
            S_IDLE:   cmd.op = s_tvalid ? OP_LATCH : OP_IDLE;
            S_START:  cmd.op = OP_START;
            S_FEED:   cmd.op = ((rep_left_reg == 2'd0) && status.is_lf) ?
                               OP_ENDLINE : OP_FEED;
            S_FLUSH:  cmd.op = OP_FLUSH;
            S_PEND:   cmd.op = OP_PEND;
            S_EOS:    cmd.op = OP_ENDLINE;
            S_DONE:   cmd.op = OP_DONE;
            S_FINISH: cmd.op = OP_FINISH;
            default:  cmd.op = OP_IDLE;
        endcase
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        rep_left_next = rep_left_reg;
        rep_idx_next  = rep_idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                rep_left_next = rep_load;
                rep_idx_next  = 1'b0;
                if (status.kind == KIND_TEXT) begin
                    if (status.is_nul || (status.bom_open && status.bom_match)) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_FEED;
                    end
                end else if (status.kind == KIND_EOS) begin
                    state_next = (rep_load != 2'd0) ? S_FEED : S_EOS;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FEED: begin
                if (!status.stall) begin
                    if (cmd.op == OP_ENDLINE) begin
                        state_next = S_FINISH;
                    end else if (status.flush_start) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next    = after_feed;
                        rep_left_next = rep_after;
                        rep_idx_next  = rep_idx_reg + (rep_left_reg != 2'd0);
                    end
                end
            end
            S_FLUSH: begin
                if (!status.stall && status.flush_last) begin
                    state_next = S_PEND;
                end
            end
            S_PEND: begin
                if (!status.stall) begin
                    state_next    = after_feed;
                    rep_left_next = rep_after;
                    rep_idx_next  = rep_idx_reg + (rep_left_reg != 2'd0);
                end
            end
            S_EOS: begin
                if (!status.stall) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!status.stall) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!status.stall) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rep_left_reg <= 2'd0;
            rep_idx_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rep_left_reg <= rep_left_next;
            rep_idx_reg  <= rep_idx_next;
        end
    end

endmodule

// ----- rtl/ini_line_stream_parser.sv -----
// top level of the ini line stream parser: controller plus datapath
//
// Input channel s_*: one item per handshake. s_tuser carries the kind (text byte,
// end of stream, consumer reject); s_tdata carries the text byte and reject line.
// Result channel m_*: one event per handshake on m_tuser, with the byte, the current
// line, the first error line and the whitespace overflow flag in m_tdata;
// m_tlast marks the last event caused by an input item.
// The block works on one input item at a time. A plain text byte is latched,
// started, classified and finished before the next item can be taken; a flush
// of held whitespace bytes adds one read of the run memory per cycle while the
// receiver does not stall, then the byte that caused the flush; a replayed partial
// byte-order mark adds one classify step per mark byte; end of stream closes the
// line and emits the stream done event. NUL bytes, absorbed mark bytes, rejects
// and unused kinds are only latched and started.
// Reset (aresetn low, synchronous) returns the parser to line one with no
// error recorded and no output pending. When m_tready is low the result register
// holds its event and the parser waits once it has an event to pass on; no event is lost.
module ini_line_stream_parser
    import ilsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // text_byte[7:0], reject_line[31:8]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_byte[7:0], line_number[31:8],
                                   // first_error[55:32], ws_overflow[56]
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic        m_tlast
);

    ilsp_cmd_t    cmd;
    ilsp_status_t status;

    ilsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ilsp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
